// ----- hw/rtl/bw_pkg.sv -----
// shared types and codes for the triangle barycentric weight pipeline
// no dependencies; used by bw_gram, bw_div, bw_post, the top level and bw_checker
`default_nettype none

package bw_pkg;

   // result case codes
   localparam logic [1:0] CASE_REGULAR = 2'd0;
   localparam logic [1:0] CASE_POINT   = 2'd1;
   localparam logic [1:0] CASE_LINE12  = 2'd2;
   localparam logic [1:0] CASE_LINE02  = 2'd3;

   // configuration register indexes
   localparam logic CSR_DET_THRESHOLD = 1'b0;
   localparam logic CSR_DOT_THRESHOLD = 1'b1;

   // control bits that travel alongside the division lanes
   typedef struct packed {
      logic [1:0] code;
      logic       lo0;   // r0 <= 0, projection clamps to zero
      logic       hi0;   // r0 >= d00, projection clamps to one
      logic       lo1;
      logic       hi1;
      logic       neg0;  // numerator sign of lane 0
      logic       neg1;
   } side_type;

endpackage

`default_nettype wire

// ----- hw/rtl/bw_front.sv -----
// front stages: edge vectors, per-axis products and the five dot products
// depends on nothing but its ports; three register stages
`default_nettype none

module bw_front #(
   parameter int CB = 24,
   localparam int E  = CB + 1,
   localparam int PW = 2 * E,
   localparam int DW = 2 * E + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic signed [CB-1:0] vtx [4][3],
   output logic                 out_valid,
   output logic signed [DW-1:0] dots [5]
);

   logic                v1_ff, v2_ff, v3_ff;
   logic signed [E-1:0] e0_ff [3];
   logic signed [E-1:0] e1_ff [3];
   logic signed [E-1:0] p_ff [3];
   logic signed [PW-1:0] pp_ff [5][3];
   logic signed [DW-1:0] dot_ff [5];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            e0_ff[i] <= E'(vtx[0][i]) - E'(vtx[2][i]);
            e1_ff[i] <= E'(vtx[1][i]) - E'(vtx[2][i]);
            p_ff[i]  <= E'(vtx[3][i]) - E'(vtx[2][i]);
            // products: e0e0, e0e1, e1e1, e0p, e1p
            pp_ff[0][i] <= e0_ff[i] * e0_ff[i];
            pp_ff[1][i] <= e0_ff[i] * e1_ff[i];
            pp_ff[2][i] <= e1_ff[i] * e1_ff[i];
            pp_ff[3][i] <= e0_ff[i] * p_ff[i];
            pp_ff[4][i] <= e1_ff[i] * p_ff[i];
         end
         for (int k = 0; k < 5; k++) begin
            dot_ff[k] <= DW'(pp_ff[k][0]) + DW'(pp_ff[k][1]) + DW'(pp_ff[k][2]);
         end
      end
   end

   assign out_valid = v3_ff;
   assign dots      = dot_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bw_wmul.sv -----
// wide signed multiplier split into four partial products over two stages
// depends on nothing but its ports
`default_nettype none

module bw_wmul #(
   parameter int W = 52,
   localparam int PW = 2 * W,
   localparam int H  = W / 2,
   localparam int HW = W - H
) (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [W-1:0]  a,
   input  logic signed [W-1:0]  b,
   output logic signed [PW-1:0] p
);

   logic signed [2*HW-1:0] hh_ff;
   logic signed [W:0]      hl_ff, lh_ff;
   logic [2*H-1:0]         ll_ff;
   logic signed [PW-1:0]   p_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         hh_ff <= $signed(a[W-1:H]) * $signed(b[W-1:H]);
         hl_ff <= $signed(a[W-1:H]) * $signed({1'b0, b[H-1:0]});
         lh_ff <= $signed({1'b0, a[H-1:0]}) * $signed(b[W-1:H]);
         ll_ff <= a[H-1:0] * b[H-1:0];
         p_ff  <= (PW'(hh_ff) <<< (2 * H)) + ((PW'(hl_ff) + PW'(lh_ff)) <<< H)
                  + $signed(PW'(ll_ff));
      end
   end

   assign p = p_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bw_gram.sv -----
// gram stages: determinant, cramer numerators, case decision, divider operands
// depends on bw_pkg and bw_wmul; six register stages
`default_nettype none

module bw_gram #(
   parameter int DW = 52,
   parameter int W  = 16,
   localparam int NW = 2 * DW + 1,
   localparam int NB = NW + W + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 adv,
   input  logic                 in_valid,
   input  logic signed [DW-1:0] dots [5],
   input  logic [31:0]          det_thr,
   input  logic [31:0]          dot_thr,
   output logic                 out_valid,
   output bw_pkg::side_type     out_side,
   output logic [NB-1:0]        num [2],
   output logic [NW-1:0]        den [2]
);

   localparam int CW = (DW > 32 ? DW : 32) + 1;
   localparam int PW = 2 * DW;
   // dot indexes
   localparam int D00 = 0;
   localparam int D01 = 1;
   localparam int D11 = 2;
   localparam int R0  = 3;
   localparam int R1  = 4;

   typedef struct packed {
      logic d00_lo;
      logic d11_lo;
      logic lo0;
      logic hi0;
      logic lo1;
      logic hi1;
   } flags_type;

   logic signed [CW-1:0] thr_c;
   logic signed [NW-1:0] thr_d;
   flags_type            fl_in;
   logic signed [PW-1:0] prod [6];

   logic                 v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff;
   flags_type            fl4_ff, fl5_ff, fl6_ff;
   logic signed [DW-1:0] raw4_ff [5];
   logic signed [DW-1:0] raw5_ff [5];
   logic signed [DW-1:0] raw6_ff [5];
   logic signed [NW-1:0] det_ff, n0_ff, n1_ff;
   bw_pkg::side_type     side7_ff, side8_ff, side9_ff;
   bw_pkg::side_type     side7_in;
   bw_pkg::side_type     side8_in;
   logic                 det_lo;
   logic signed [NW-1:0] num7_ff [2];
   logic [NW-1:0]        den7_ff [2];
   logic [NW-1:0]        mag8_ff [2];
   logic [NW-1:0]        den8_ff [2];
   logic [NB-1:0]        num9_ff [2];
   logic [NW-1:0]        den9_ff [2];

   bw_wmul #(.W(DW)) u_m0 (.clock, .adv, .a(dots[D00]), .b(dots[D11]), .p(prod[0]));
   bw_wmul #(.W(DW)) u_m1 (.clock, .adv, .a(dots[D01]), .b(dots[D01]), .p(prod[1]));
   bw_wmul #(.W(DW)) u_m2 (.clock, .adv, .a(dots[D11]), .b(dots[R0]),  .p(prod[2]));
   bw_wmul #(.W(DW)) u_m3 (.clock, .adv, .a(dots[D01]), .b(dots[R1]),  .p(prod[3]));
   bw_wmul #(.W(DW)) u_m4 (.clock, .adv, .a(dots[D00]), .b(dots[R1]),  .p(prod[4]));
   bw_wmul #(.W(DW)) u_m5 (.clock, .adv, .a(dots[D01]), .b(dots[R0]),  .p(prod[5]));

   always_comb begin
      thr_c = $signed(CW'({1'b0, dot_thr}));
      fl_in.d00_lo = (dots[D00] == '0) || (CW'(dots[D00]) < thr_c);
      fl_in.d11_lo = (dots[D11] == '0) || (CW'(dots[D11]) < thr_c);
      fl_in.lo0    = dots[R0][DW-1] || (dots[R0] == '0);
      fl_in.hi0    = dots[R0] >= dots[D00];
      fl_in.lo1    = dots[R1][DW-1] || (dots[R1] == '0);
      fl_in.hi1    = dots[R1] >= dots[D11];
   end

   always_comb begin
      thr_d  = $signed(NW'({1'b0, det_thr}));
      det_lo = (det_ff == '0) || (det_ff < thr_d);
      side7_in      = '0;
      side7_in.lo0  = fl6_ff.lo0;
      side7_in.hi0  = fl6_ff.hi0;
      side7_in.lo1  = fl6_ff.lo1;
      side7_in.hi1  = fl6_ff.hi1;
      if (!det_lo) begin
         side7_in.code = bw_pkg::CASE_REGULAR;
      end else if (!fl6_ff.d00_lo) begin
         side7_in.code = bw_pkg::CASE_LINE02;
      end else if (!fl6_ff.d11_lo) begin
         side7_in.code = bw_pkg::CASE_LINE12;
      end else begin
         side7_in.code = bw_pkg::CASE_POINT;
      end
   end

   always_comb begin
      side8_in      = side7_ff;
      side8_in.neg0 = num7_ff[0][NW-1];
      side8_in.neg1 = num7_ff[1][NW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
         v8_ff <= 1'b0;
         v9_ff <= 1'b0;
      end else if (adv) begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
         v8_ff <= v7_ff;
         v9_ff <= v8_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fl4_ff  <= fl_in;
         fl5_ff  <= fl4_ff;
         fl6_ff  <= fl5_ff;
         raw4_ff <= dots;
         raw5_ff <= raw4_ff;
         raw6_ff <= raw5_ff;
         det_ff  <= NW'(prod[0]) - NW'(prod[1]);
         n0_ff   <= NW'(prod[2]) - NW'(prod[3]);
         n1_ff   <= NW'(prod[4]) - NW'(prod[5]);

         // degenerate cases reuse the lanes for the edge projections
         side7_ff <= side7_in;
         if (side7_in.code == bw_pkg::CASE_LINE02) begin
            num7_ff[0] <= NW'(raw6_ff[R0]);
            den7_ff[0] <= NW'(raw6_ff[D00]);
         end else begin
            num7_ff[0] <= n0_ff;
            den7_ff[0] <= det_ff;
         end
         if (side7_in.code == bw_pkg::CASE_LINE12) begin
            num7_ff[1] <= NW'(raw6_ff[R1]);
            den7_ff[1] <= NW'(raw6_ff[D11]);
         end else begin
            num7_ff[1] <= n1_ff;
            den7_ff[1] <= det_ff;
         end

         side8_ff <= side8_in;
         for (int l = 0; l < 2; l++) begin
            mag8_ff[l] <= num7_ff[l][NW-1] ? NW'(-num7_ff[l]) : NW'(num7_ff[l]);
            den8_ff[l] <= den7_ff[l];
         end

         // round to nearest: (2*mag*one + den) / (2*den)
         side9_ff <= side8_ff;
         for (int l = 0; l < 2; l++) begin
            num9_ff[l] <= (NB'(mag8_ff[l]) << (W + 1)) + NB'(den8_ff[l]);
            den9_ff[l] <= den8_ff[l] << 1;
         end
      end
   end

   assign out_valid = v9_ff;
   assign out_side  = side9_ff;
   assign num       = num9_ff;
   assign den       = den9_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/bw_div.sv -----
// two-lane pipelined restoring divider, one quotient bit per stage
// depends on bw_pkg for the side bits carried along
`default_nettype none

module bw_div #(
   parameter int NB = 122,
   parameter int DB = 105
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  bw_pkg::side_type  in_side,
   input  logic [NB-1:0]     num [2],
   input  logic [DB-1:0]     den [2],
   output logic              out_valid,
   output bw_pkg::side_type  out_side,
   output logic [NB-1:0]     quo [2]
);

   logic [DB-1:0]    rem_ff [2][NB];
   logic [NB-1:0]    num_ff [2][NB];
   logic [NB-1:0]    q_ff [2][NB];
   logic [DB-1:0]    den_ff [2][NB];
   logic             vld_ff [NB];
   bw_pkg::side_type side_ff [NB];

   for (genvar s = 0; s < NB; s++) begin : g_stage
      if (s == 0) begin : g_first
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (adv) begin
               vld_ff[s] <= in_valid;
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               side_ff[s] <= in_side;
            end
         end
      end else begin : g_next
         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[s] <= 1'b0;
            end else if (adv) begin
               vld_ff[s] <= vld_ff[s-1];
            end
         end
         always_ff @(posedge clock) begin
            if (adv) begin
               side_ff[s] <= side_ff[s-1];
            end
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [DB-1:0] rem_p, den_p;
         logic [NB-1:0] num_p, q_p;
         logic [DB:0]   sh, df;

         if (s == 0) begin : g_src
            assign rem_p = '0;
            assign den_p = den[l];
            assign num_p = num[l];
            assign q_p   = '0;
         end else begin : g_src
            assign rem_p = rem_ff[l][s-1];
            assign den_p = den_ff[l][s-1];
            assign num_p = num_ff[l][s-1];
            assign q_p   = q_ff[l][s-1];
         end

         assign sh = {rem_p, num_p[NB-1-s]};
         assign df = sh - {1'b0, den_p};

         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[l][s] <= df[DB] ? sh[DB-1:0] : df[DB-1:0];
               den_ff[l][s] <= den_p;
               num_ff[l][s] <= num_p;
               q_ff[l][s]   <= q_p | (NB'(!df[DB]) << (NB - 1 - s));
            end
         end
      end
   end

   assign out_valid = vld_ff[NB-1];
   assign out_side  = side_ff[NB-1];
   assign quo[0]    = q_ff[0][NB-1];
   assign quo[1]    = q_ff[1][NB-1];

endmodule

`default_nettype wire

// ----- hw/rtl/bw_post.sv -----
// output stage: sign restore, clamped projections, third weight, saturation
// depends on bw_pkg; holds the result register
`default_nettype none

module bw_post #(
   parameter int NB = 122,
   parameter int W  = 16,
   localparam int XW = NB + 3
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  bw_pkg::side_type    in_side,
   input  logic [NB-1:0]       quo [2],
   output logic                out_valid,
   output logic signed [31:0]  weight [3],
   output logic [1:0]          case_code,
   output logic                saturated
);

   localparam logic signed [XW-1:0] ONE = XW'(1) << W;

   logic signed [XW-1:0] qs [2];
   logic signed [XW-1:0] t0, t1;
   logic signed [XW-1:0] x [3];
   logic signed [31:0]   w_in [3];
   logic [2:0]           ovf;

   logic                 valid_ff;
   logic signed [31:0]   weight_ff [3];
   logic [1:0]           code_ff;
   logic                 sat_ff;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         qs[l] = XW'(quo[l]);
      end
      if (in_side.neg0) qs[0] = -qs[0];
      if (in_side.neg1) qs[1] = -qs[1];
      t0 = in_side.lo0 ? '0 : (in_side.hi0 ? ONE : qs[0]);
      t1 = in_side.lo1 ? '0 : (in_side.hi1 ? ONE : qs[1]);
      unique case (in_side.code)
         bw_pkg::CASE_REGULAR: begin
            x[0] = qs[0];
            x[1] = qs[1];
            x[2] = ONE - qs[0] - qs[1];
         end
         bw_pkg::CASE_POINT: begin
            x[0] = ONE;
            x[1] = '0;
            x[2] = '0;
         end
         bw_pkg::CASE_LINE12: begin
            x[0] = '0;
            x[1] = t1;
            x[2] = ONE - t1;
         end
         bw_pkg::CASE_LINE02: begin
            x[0] = t0;
            x[1] = '0;
            x[2] = ONE - t0;
         end
         default: begin
            x[0] = '0;
            x[1] = '0;
            x[2] = '0;
         end
      endcase
      for (int k = 0; k < 3; k++) begin
         // fits when every bit above bit 31 copies the sign
         ovf[k] = !((&x[k][XW-1:31]) || !(|x[k][XW-1:31]));
         if (ovf[k]) begin
            w_in[k] = x[k][XW-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
         end else begin
            w_in[k] = x[k][31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         weight_ff <= w_in;
         code_ff   <= in_side.code;
         sat_ff    <= |ovf;
      end
   end

   assign out_valid = valid_ff;
   assign weight    = weight_ff;
   assign case_code = code_ff;
   assign saturated = sat_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/triangle_barycentric_weights.sv -----
// top level of the barycentric weight pipeline
// depends on bw_pkg, bw_front, bw_wmul, bw_gram, bw_div and bw_post
//
// usage: one item on the req_ channel holds three vertices and a query point
// (signed, 8 fraction bits); one item on the rsp_ channel returns the three
// weights (16 fraction bits by default), the case code and a saturation flag.
// an item is taken at a clock edge where valid is high and stall is low.
// throughput: one item per cycle while nothing stalls. the divider resolves one
// quotient bit per stage over 4*COORD_BITS + WEIGHT_FRAC_BITS + 10 stages.
// the whole pipeline advances together: while rsp_valid is high and
// rsp_stall is high every stage holds, req_stall goes high and no item is
// lost or repeated; the pipeline keeps taking items while the result
// register is empty or being drained. thresholds are written through
// csr_write/csr_index/csr_wdata by the user only while idle (not enforced);
// reset clears all valid bits and sets both thresholds to 1.
`default_nettype none

module triangle_barycentric_weights #(
   parameter int COORD_BITS       = 24,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_BITS-1:0]  req_v0_x,
   input  logic signed [COORD_BITS-1:0]  req_v0_y,
   input  logic signed [COORD_BITS-1:0]  req_v0_z,
   input  logic signed [COORD_BITS-1:0]  req_v1_x,
   input  logic signed [COORD_BITS-1:0]  req_v1_y,
   input  logic signed [COORD_BITS-1:0]  req_v1_z,
   input  logic signed [COORD_BITS-1:0]  req_v2_x,
   input  logic signed [COORD_BITS-1:0]  req_v2_y,
   input  logic signed [COORD_BITS-1:0]  req_v2_z,
   input  logic signed [COORD_BITS-1:0]  req_pos_x,
   input  logic signed [COORD_BITS-1:0]  req_pos_y,
   input  logic signed [COORD_BITS-1:0]  req_pos_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_weight0,
   output logic signed [31:0]            rsp_weight1,
   output logic signed [31:0]            rsp_weight2,
   output logic [1:0]                    rsp_case_code,
   output logic                          rsp_saturated,
   input  logic                          csr_write,
   input  logic                          csr_index,
   input  logic [31:0]                   csr_wdata
);

   localparam int DW = 2 * COORD_BITS + 4;
   localparam int NW = 2 * DW + 1;
   localparam int NB = NW + WEIGHT_FRAC_BITS + 1;

   logic                       adv;
   logic [31:0]                det_thr_ff, dot_thr_ff;
   logic signed [COORD_BITS-1:0] vtx [4][3];
   logic                       f_valid, g_valid, d_valid;
   logic signed [DW-1:0]       dots [5];
   bw_pkg::side_type           g_side, d_side;
   logic [NB-1:0]              g_num [2];
   logic [NW-1:0]              g_den [2];
   logic [NB-1:0]              d_quo [2];
   logic signed [31:0]         weight [3];

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         det_thr_ff <= 32'd1;
         dot_thr_ff <= 32'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            bw_pkg::CSR_DET_THRESHOLD: det_thr_ff <= csr_wdata;
            bw_pkg::CSR_DOT_THRESHOLD: dot_thr_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign vtx[0][0] = req_v0_x;
   assign vtx[0][1] = req_v0_y;
   assign vtx[0][2] = req_v0_z;
   assign vtx[1][0] = req_v1_x;
   assign vtx[1][1] = req_v1_y;
   assign vtx[1][2] = req_v1_z;
   assign vtx[2][0] = req_v2_x;
   assign vtx[2][1] = req_v2_y;
   assign vtx[2][2] = req_v2_z;
   assign vtx[3][0] = req_pos_x;
   assign vtx[3][1] = req_pos_y;
   assign vtx[3][2] = req_pos_z;

   bw_front #(.CB(COORD_BITS)) u_front (
      .clock, .reset, .adv,
      .in_valid  (req_valid),
      .vtx       (vtx),
      .out_valid (f_valid),
      .dots      (dots)
   );

   bw_gram #(.DW(DW), .W(WEIGHT_FRAC_BITS)) u_gram (
      .clock, .reset, .adv,
      .in_valid  (f_valid),
      .dots      (dots),
      .det_thr   (det_thr_ff),
      .dot_thr   (dot_thr_ff),
      .out_valid (g_valid),
      .out_side  (g_side),
      .num       (g_num),
      .den       (g_den)
   );

   bw_div #(.NB(NB), .DB(NW)) u_div (
      .clock, .reset, .adv,
      .in_valid  (g_valid),
      .in_side   (g_side),
      .num       (g_num),
      .den       (g_den),
      .out_valid (d_valid),
      .out_side  (d_side),
      .quo       (d_quo)
   );

   bw_post #(.NB(NB), .W(WEIGHT_FRAC_BITS)) u_post (
      .clock, .reset, .adv,
      .in_valid  (d_valid),
      .in_side   (d_side),
      .quo       (d_quo),
      .out_valid (rsp_valid),
      .weight    (weight),
      .case_code (rsp_case_code),
      .saturated (rsp_saturated)
   );

   assign rsp_weight0 = weight[0];
   assign rsp_weight1 = weight[1];
   assign rsp_weight2 = weight[2];

endmodule

`default_nettype wire

// ----- hw/rtl/bw_checker.sv -----
// port-level checks for triangle_barycentric_weights, bound to the top level
// depends on bw_pkg for the case codes
`default_nettype none

module bw_checker #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [31:0] rsp_weight0,
   input wire logic signed [31:0] rsp_weight1,
   input wire logic signed [31:0] rsp_weight2,
   input wire logic [1:0]         rsp_case_code,
   input wire logic               rsp_saturated
);

   localparam logic signed [31:0] ONE = 32'(1) << WEIGHT_FRAC_BITS;

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_weight0)
         && $stable(rsp_weight1) && $stable(rsp_weight2) && $stable(rsp_case_code))
      else $error("stalled result changed");

   // a held result backs up into the input side
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input not stalled while result is held");

   a_point: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_case_code == bw_pkg::CASE_POINT |->
         rsp_weight0 == ONE && rsp_weight1 == 0 && rsp_weight2 == 0 && !rsp_saturated)
      else $error("coincident vertex weights wrong");

   // edge projections stay in [0, one] and sum to one
   a_line02: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_case_code == bw_pkg::CASE_LINE02 |->
         rsp_weight1 == 0 && rsp_weight0 >= 0 && rsp_weight0 <= ONE
         && rsp_weight0 + rsp_weight2 == ONE && !rsp_saturated)
      else $error("line v0-v2 weights wrong");

   a_line12: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_case_code == bw_pkg::CASE_LINE12 |->
         rsp_weight0 == 0 && rsp_weight1 >= 0 && rsp_weight1 <= ONE
         && rsp_weight1 + rsp_weight2 == ONE && !rsp_saturated)
      else $error("line v1-v2 weights wrong");

endmodule

bind triangle_barycentric_weights bw_checker #(
   .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
) u_bw_checker (
   .clock, .reset, .req_stall, .rsp_valid, .rsp_stall,
   .rsp_weight0, .rsp_weight1, .rsp_weight2, .rsp_case_code, .rsp_saturated
);

`default_nettype wire
